// ----- hw/rtl/aabb_pkg.sv -----
// Shared word sizes, number format and stage payload types for the
// transformed bounding box pipeline. No dependencies.
package aabb_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int AXIS_BITS = 2;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [ACC_BITS-1:0]  acc_t;
  typedef logic [AXIS_BITS-1:0]        axis_t;

  typedef struct packed {
    axis_t axis;
    word_t coef_x;
    word_t coef_y;
    word_t coef_z;
    word_t coef_t;
    word_t lo_x;
    word_t lo_y;
    word_t lo_z;
    word_t hi_x;
    word_t hi_y;
    word_t hi_z;
  } req_t;

  typedef struct packed {
    axis_t axis;
    word_t coef_t;
    prod_t lo_x;
    prod_t lo_y;
    prod_t lo_z;
    prod_t hi_x;
    prod_t hi_y;
    prod_t hi_z;
  } prod_set_t;

  typedef struct packed {
    axis_t axis;
    word_t coef_t;
    prod_t mn_x;
    prod_t mn_y;
    prod_t mn_z;
    prod_t mx_x;
    prod_t mx_y;
    prod_t mx_z;
  } bound_set_t;

  typedef struct packed {
    axis_t axis;
    acc_t  mn_a;
    acc_t  mn_b;
    acc_t  mx_a;
    acc_t  mx_b;
  } part_sum_t;

endpackage

// ----- hw/rtl/aabb_transform_bounds.sv -----
// Top level of the transformed bounding box pipeline: four register stages.
// Depends on aabb_pkg and the aabb_* stage modules.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   input   | in_valid / in_ready  | axis, coef_x..coef_t, lo_x..lo_z, hi_x..hi_z
//   output  | out_valid / out_ready| axis_out, out_min, out_max
//
// One request per cycle unless stalled; out_valid rises once it reaches the last stage.
// Each stage holds one request and has its own datapath, so a request can enter every cycle.
// Reset clears only the stage valid bits; payload registers are left as they are.
// A stall holds each full stage; an empty stage still takes a request, so bubbles close up.
module aabb_transform_bounds import aabb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  axis_t axis,
  input  word_t coef_x,
  input  word_t coef_y,
  input  word_t coef_z,
  input  word_t coef_t,
  input  word_t lo_x,
  input  word_t lo_y,
  input  word_t lo_z,
  input  word_t hi_x,
  input  word_t hi_y,
  input  word_t hi_z,
  output logic  out_valid,
  input  logic  out_ready,
  output axis_t axis_out,
  output word_t out_min,
  output word_t out_max
);

  req_t       req;
  logic       s1_valid;
  logic       s1_ready;
  prod_set_t  s1_req;
  logic       s2_valid;
  logic       s2_ready;
  bound_set_t s2_req;
  logic       s3_valid;
  logic       s3_ready;
  part_sum_t  s3_req;

  assign req.axis   = axis;
  assign req.coef_x = coef_x;
  assign req.coef_y = coef_y;
  assign req.coef_z = coef_z;
  assign req.coef_t = coef_t;
  assign req.lo_x   = lo_x;
  assign req.lo_y   = lo_y;
  assign req.lo_z   = lo_z;
  assign req.hi_x   = hi_x;
  assign req.hi_y   = hi_y;
  assign req.hi_z   = hi_z;

  aabb_corner_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (req),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_req   (s1_req)
  );

  aabb_axis_select u_sel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_req    (s1_req),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_req   (s2_req)
  );

  aabb_accum u_acc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_req    (s2_req),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_req   (s3_req)
  );

  aabb_round_sat u_rnd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_req    (s3_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .axis_out  (axis_out),
    .out_min   (out_min),
    .out_max   (out_max)
  );

endmodule

// ----- hw/rtl/aabb_corner_mul.sv -----
// Stage one: the six exact coefficient by coordinate products.
// Depends on aabb_pkg.
module aabb_corner_mul import aabb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  req_t      in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output prod_set_t out_req
);

  logic      vld;
  prod_set_t data;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_req   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.axis   <= in_req.axis;
      data.coef_t <= in_req.coef_t;
      data.lo_x   <= $signed(in_req.coef_x) * $signed(in_req.lo_x);
      data.lo_y   <= $signed(in_req.coef_y) * $signed(in_req.lo_y);
      data.lo_z   <= $signed(in_req.coef_z) * $signed(in_req.lo_z);
      data.hi_x   <= $signed(in_req.coef_x) * $signed(in_req.hi_x);
      data.hi_y   <= $signed(in_req.coef_y) * $signed(in_req.hi_y);
      data.hi_z   <= $signed(in_req.coef_z) * $signed(in_req.hi_z);
    end
  end

endmodule

// ----- hw/rtl/aabb_axis_select.sv -----
// Stage two: per local axis, pick the smaller and larger product.
// Depends on aabb_pkg.
module aabb_axis_select import aabb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  prod_set_t  in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output bound_set_t out_req
);

  logic       vld;
  bound_set_t data;
  logic       lt_x;
  logic       lt_y;
  logic       lt_z;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_req   = data;

  assign lt_x = $signed(in_req.lo_x) < $signed(in_req.hi_x);
  assign lt_y = $signed(in_req.lo_y) < $signed(in_req.hi_y);
  assign lt_z = $signed(in_req.lo_z) < $signed(in_req.hi_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.axis   <= in_req.axis;
      data.coef_t <= in_req.coef_t;
      data.mn_x   <= lt_x ? in_req.lo_x : in_req.hi_x;
      data.mx_x   <= lt_x ? in_req.hi_x : in_req.lo_x;
      data.mn_y   <= lt_y ? in_req.lo_y : in_req.hi_y;
      data.mx_y   <= lt_y ? in_req.hi_y : in_req.lo_y;
      data.mn_z   <= lt_z ? in_req.lo_z : in_req.hi_z;
      data.mx_z   <= lt_z ? in_req.hi_z : in_req.lo_z;
    end
  end

endmodule

// ----- hw/rtl/aabb_accum.sv -----
// Stage three: partial sums of the bounds, scaled translation and rounding half.
// Depends on aabb_pkg.
module aabb_accum import aabb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  bound_set_t in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output part_sum_t  out_req
);

  localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);

  logic      vld;
  part_sum_t data;
  acc_t      trans;
  acc_t      mn_x;
  acc_t      mn_y;
  acc_t      mn_z;
  acc_t      mx_x;
  acc_t      mx_y;
  acc_t      mx_z;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_req   = data;

  assign trans = {{(ACC_BITS-WORD_BITS){in_req.coef_t[WORD_BITS-1]}}, in_req.coef_t}
                 <<< FRAC_BITS;
  assign mn_x  = {{(ACC_BITS-PROD_BITS){in_req.mn_x[PROD_BITS-1]}}, in_req.mn_x};
  assign mn_y  = {{(ACC_BITS-PROD_BITS){in_req.mn_y[PROD_BITS-1]}}, in_req.mn_y};
  assign mn_z  = {{(ACC_BITS-PROD_BITS){in_req.mn_z[PROD_BITS-1]}}, in_req.mn_z};
  assign mx_x  = {{(ACC_BITS-PROD_BITS){in_req.mx_x[PROD_BITS-1]}}, in_req.mx_x};
  assign mx_y  = {{(ACC_BITS-PROD_BITS){in_req.mx_y[PROD_BITS-1]}}, in_req.mx_y};
  assign mx_z  = {{(ACC_BITS-PROD_BITS){in_req.mx_z[PROD_BITS-1]}}, in_req.mx_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.axis <= in_req.axis;
      data.mn_a <= mn_x + mn_y;
      data.mn_b <= mn_z + trans + ROUND_HALF;
      data.mx_a <= mx_x + mx_y;
      data.mx_b <= mx_z + trans + ROUND_HALF;
    end
  end

endmodule

// ----- hw/rtl/aabb_round_sat.sv -----
// Stage four: final add, drop the fraction and saturate into the output register.
// Depends on aabb_pkg.
module aabb_round_sat import aabb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  part_sum_t in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output axis_t     axis_out,
  output word_t     out_min,
  output word_t     out_max
);

  localparam acc_t SAT_HI = acc_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam acc_t SAT_LO = -SAT_HI - acc_t'(1);

  logic  vld;
  axis_t axis_q;
  word_t mn_q;
  word_t mx_q;
  acc_t  mn_sh;
  acc_t  mx_sh;
  word_t mn_next;
  word_t mx_next;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign axis_out  = axis_q;
  assign out_min   = mn_q;
  assign out_max   = mx_q;

  assign mn_sh = (in_req.mn_a + in_req.mn_b) >>> FRAC_BITS;
  assign mx_sh = (in_req.mx_a + in_req.mx_b) >>> FRAC_BITS;

  always_comb begin
    if (mn_sh > SAT_HI) begin
      mn_next = SAT_HI[WORD_BITS-1:0];
    end else if (mn_sh < SAT_LO) begin
      mn_next = SAT_LO[WORD_BITS-1:0];
    end else begin
      mn_next = mn_sh[WORD_BITS-1:0];
    end
    if (mx_sh > SAT_HI) begin
      mx_next = SAT_HI[WORD_BITS-1:0];
    end else if (mx_sh < SAT_LO) begin
      mx_next = SAT_LO[WORD_BITS-1:0];
    end else begin
      mx_next = mx_sh[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      axis_q <= in_req.axis;
      mn_q   <= mn_next;
      mx_q   <= mx_next;
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for aabb_transform_bounds under bursty traffic: directed rows
// and then random requests, matched to listed bounds or an eight-corner predictor.
// Depends on aabb_pkg and the aabb_transform_bounds RTL.
module testbench;
  import aabb_pkg::*;

  localparam int    RANDOM_ITEMS = 1250;
  localparam int    HOLD_START   = 1500;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    DRAIN_LIMIT  = 20000;
  localparam int    TAIL_CYCLES  = 8;
  localparam int    PRINT_LIMIT  = 100;
  localparam int    ACCW         = 2 * WORD_BITS + 4;
  localparam word_t ONE          = word_t'(1) <<< FRAC_BITS;
  localparam word_t WMAX         = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN         = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum int {PROFILE_FULL, PROFILE_SMALL, PROFILE_HOT, PROFILE_EXTREME} profile_t;

  typedef struct packed {
    axis_t axis;
    word_t mn;
    word_t mx;
  } bounds_t;

  typedef struct packed {
    req_t    req;
    logic    typed;
    bounds_t want;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  axis_t axis;
  word_t coef_x, coef_y, coef_z, coef_t;
  word_t lo_x, lo_y, lo_z;
  word_t hi_x, hi_y, hi_z;
  logic  out_valid;
  logic  out_ready;
  axis_t axis_out;
  word_t out_min, out_max;

  bounds_t   pending_bounds[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;

  aabb_transform_bounds dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .axis(axis), .coef_x(coef_x), .coef_y(coef_y), .coef_z(coef_z), .coef_t(coef_t),
    .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .axis_out(axis_out), .out_min(out_min), .out_max(out_max)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  function automatic bounds_t corner_bounds(req_t r);
    logic signed [ACCW-1:0] cx, cy, cz, base, acc, rounded, wide;
    logic signed [ACCW-1:0] xs[2], ys[2], zs[2];
    word_t   v, mn, mx;
    bounds_t b;
    int      k;
    cx = ACCW'(r.coef_x);
    cy = ACCW'(r.coef_y);
    cz = ACCW'(r.coef_z);
    base = ACCW'(r.coef_t);
    base = base <<< FRAC_BITS;
    xs[0] = ACCW'(r.lo_x); xs[1] = ACCW'(r.hi_x);
    ys[0] = ACCW'(r.lo_y); ys[1] = ACCW'(r.hi_y);
    zs[0] = ACCW'(r.lo_z); zs[1] = ACCW'(r.hi_z);
    mn = '0;
    mx = '0;
    for (k = 0; k < 8; k++) begin
      acc = base + cx * xs[k[2]] + cy * ys[k[1]] + cz * zs[k[0]];
      rounded = (acc + (ACCW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      v = rounded[WORD_BITS-1:0];
      wide = ACCW'(v);
      if (wide != rounded) v = rounded[ACCW-1] ? WMIN : WMAX;
      if (k == 0 || v < mn) mn = v;
      if (k == 0 || v > mx) mx = v;
    end
    b.axis = r.axis;
    b.mn = mn;
    b.mx = mx;
    return b;
  endfunction

  function automatic word_t random_word(profile_t profile, bit is_coef);
    word_t w;
    w = $urandom;
    case (profile)
      PROFILE_SMALL: begin
        w = is_coef ? (w >>> 14) : (w >>> 6);
      end
      PROFILE_HOT: begin
        if (is_coef) w = w >>> 8;
      end
      PROFILE_EXTREME: begin
        case ($urandom_range(0, 5))
          0: w = WMIN;
          1: w = WMAX;
          2: w = '0;
          3: w = ONE;
          4: w = -1;
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic add_row(axis_t ax, word_t cx, word_t cy, word_t cz, word_t ct,
                         word_t lx, word_t ly, word_t lz, word_t hx, word_t hy, word_t hz,
                         logic typed, word_t wmin, word_t wmax);
    stim_row_t row;
    row.req = {ax, cx, cy, cz, ct, lx, ly, lz, hx, hy, hz};
    row.typed = typed;
    row.want = {ax, wmin, wmax};
    directed_rows = {directed_rows, row};
  endtask

  initial begin : drive_requests
    stim_row_t row;
    profile_t  profile;
    word_t     words[10];
    int        idx, f, pick, burst, gap, total, waited;
    rst <= 1'b1;
    in_valid <= 1'b0;
    {axis, coef_x, coef_y, coef_z, coef_t, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z} <= req_t'(0);

    add_row(2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0);
    add_row(2'd1, ONE, 0, 0, 0, -ONE, 0, 0, 2 * ONE, 0, 0, 1'b1, -ONE, 2 * ONE);
    add_row(2'd2, 0, 0, 0, 5 * ONE, 0, 0, 0, 0, 0, 0, 1'b1, 5 * ONE, 5 * ONE);
    add_row(2'd3, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, 1'b1, ONE, ONE);
    add_row(2'd1, 0, ONE, 0, 0, 0, 3 * ONE, 0, 0, -2 * ONE, 0, 1'b1, -2 * ONE, 3 * ONE);
    add_row(2'd0, -ONE, 0, 0, 10 * ONE, ONE, 0, 0, 3 * ONE, 0, 0, 1'b1, 7 * ONE, 9 * ONE);
    add_row(2'd0, WMAX, 0, 0, 0, WMAX, 0, 0, WMAX, 0, 0, 1'b1, WMAX, WMAX);
    add_row(2'd2, 0, 0, WMIN, 0, 0, 0, WMAX, 0, 0, WMAX, 1'b1, WMIN, WMIN);
    add_row(2'd0, WMAX, 0, 0, 0, WMIN, 0, 0, WMAX, 0, 0, 1'b1, WMIN, WMAX);
    add_row(2'd1, 1, 0, 0, 0, 32'sh8000, 0, 0, 32'sh8000, 0, 0, 1'b1, 1, 1);
    add_row(2'd1, -1, 0, 0, 0, 32'sh8000, 0, 0, 32'sh8000, 0, 0, 1'b1, 0, 0);
    add_row(2'd2, 0, 0, 0, WMAX, 0, 0, 0, 0, 0, 0, 1'b1, WMAX, WMAX);
    add_row(2'd0, 0, 0, 0, WMIN, 0, 0, 0, 0, 0, 0, 1'b1, WMIN, WMIN);
    add_row(2'd0, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 1'b0, 0, 0);
    add_row(2'd3, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 1'b0, 0, 0);
    add_row(2'd1, -(ONE + ONE / 2), 2 * ONE + ONE / 4, (3 * ONE) / 4, 10 * ONE,
            -ONE, -2 * ONE, -3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE, 1'b0, 0, 0);
    add_row(2'd2, WMIN, WMAX, -1, 1, WMAX, WMIN, 1, WMIN, WMAX, -1, 1'b0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    total = directed_rows.size() + RANDOM_ITEMS;
    burst = 0;
    for (idx = 0; idx < total; idx++) begin
      if (idx < directed_rows.size()) begin
        row = directed_rows[idx];
      end else begin
        pick = $urandom_range(0, 19);
        profile = (pick < 4) ? PROFILE_FULL : (pick < 12) ? PROFILE_SMALL :
                  (pick < 17) ? PROFILE_HOT : PROFILE_EXTREME;
        for (f = 0; f < 10; f++) words[f] = random_word(profile, f < 4);
        row.typed = 1'b0;
        row.want = '0;
        row.req = {($urandom_range(0, 9) == 0) ? axis_t'(3) : axis_t'($urandom_range(0, 2)),
                   words[0], words[1], words[2], words[3], words[4],
                   words[5], words[6], words[7], words[8], words[9]};
      end
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      {axis, coef_x, coef_y, coef_z, coef_t, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z} <= row.req;
      in_valid <= 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      pending_bounds = {pending_bounds, row.typed ? row.want : corner_bounds(row.req)};
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_bounds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_bounds.size() != 0)
      report_mismatch("requests left without a result", pending_bounds.size(), 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** aabb_transform_bounds: PASSED **");
    else
      $display("** aabb_transform_bounds: FAILED **");
    $finish;
  end

  initial begin : accept_results
    int cycle, span, mode;
    out_ready <= 1'b0;
    cycle = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk);
        cycle++;
        if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
          out_ready <= 1'b0;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    bounds_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bounds.size() == 0) begin
        report_mismatch("result with no request pending", out_min, 0);
      end else begin
        want = pending_bounds.pop_front();
        if (axis_out !== want.axis)
          report_mismatch("axis_out", 32'(axis_out), 32'(want.axis));
        if (out_min !== want.mn) report_mismatch("out_min", out_min, want.mn);
        if (out_max !== want.mx) report_mismatch("out_max", out_max, want.mx);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("** aabb_transform_bounds: FAILED **");
    $finish;
  end

endmodule
